FILE: hdl/servo_pwm_generator_defines.svh
`ifndef SERVO_PWM_GENERATOR_DEFINES_SVH
`define SERVO_PWM_GENERATOR_DEFINES_SVH
`ifndef SYNTH
`define SPG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spg: implication check failed");
`define SPG_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spg: next-cycle check failed");
`else
`define SPG_ASSERT_IMP(label, clk, rst, ante, cons)
`define SPG_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/spg_pkg.sv
package spg_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ANGLE = 2'd1,
    CMD_PULSE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_PULSE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_PULSE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MIN_ANGLE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_ANGLE  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PRESCALE   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD_TOP = 3'd6;

  localparam logic [15:0] RST_MIN_PULSE  = 16'd544;
  localparam logic [15:0] RST_MAX_PULSE  = 16'd2400;
  localparam logic [15:0] RST_MIN_ANGLE  = 16'd0;
  localparam logic [15:0] RST_MAX_ANGLE  = 16'd180;
  localparam logic [15:0] RST_PRESCALE   = 16'd71;
  localparam logic [15:0] RST_PERIOD_TOP = 16'd19999;

  localparam int QUEUE_DEPTH = 2;

  localparam int ARG_W  = 17;
  localparam int OP_W   = 18;
  localparam int PROD_W = 2 * OP_W;
  localparam int MAG_W  = 34;
  localparam int DEN_W  = 17;
  localparam int CNT_W  = $clog2(MAG_W);
  localparam int RES_W  = 36;

  localparam logic signed [RES_W-1:0] ANG_MIN = RES_W'(-32768);
  localparam logic signed [RES_W-1:0] ANG_MAX = RES_W'(32767);

  typedef struct packed {
    logic        enable;
    logic [15:0] min_pulse_us;
    logic [15:0] max_pulse_us;
    logic [15:0] min_angle;
    logic [15:0] max_angle;
    logic [15:0] prescale;
    logic [15:0] period_top;
  } cfg_t;

  typedef struct packed {
    cmd_t        kind;
    logic [15:0] value;
  } q_entry_t;

  typedef struct packed {
    logic             start;
    logic [ARG_W-1:0] x;
    logic [ARG_W-1:0] in_lo;
    logic [ARG_W-1:0] in_hi;
    logic [ARG_W-1:0] out_lo;
    logic [ARG_W-1:0] out_hi;
  } map_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [RES_W-1:0] result;
  } map_rsp_t;

  typedef enum logic [2:0] {
    MS_IDLE,
    MS_MUL,
    MS_PREP,
    MS_DIV,
    MS_FIX,
    MS_DONE
  } map_state_t;

  typedef enum logic [1:0] {
    EX_RUN,
    EX_ANGLE,
    EX_READ
  } exec_state_t;

endpackage

FILE: hdl/spg_ifs.sv
interface spg_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [15:0] value;
  modport source(output valid, output command, output value, input ready);
  modport sink(input valid, input command, input value, output ready);
endinterface

interface spg_res_if;
  logic               valid;
  logic               ready;
  logic               pwm_level;
  logic [15:0]        pulse_readback;
  logic signed [15:0] angle_readback;
  modport source(output valid, output pwm_level, output pulse_readback,
                 output angle_readback, input ready);
  modport sink(input valid, input pwm_level, input pulse_readback,
               input angle_readback, output ready);
endinterface

interface spg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

FILE: hdl/servo_pwm_generator.sv
// Servo pulse generator.
// Channels: item (command, value) in, result (pwm_level, pulse_readback,
// angle_readback) out, cfg (index, data) for the seven setup registers;
// cfg is always ready and takes effect on the next item.
// Every item gives exactly one result, in order. A tick item whose angle
// readback is current passes through the queue entry and the output
// register, and ticks stream at one per cycle while the receiver keeps up.
// A pulse write while enabled, or any item after a register write,
// recomputes the readback through the shared multiply/divide unit, which
// makes one quotient bit per cycle over 34 bits. An angle write while
// enabled maps the angle through the same unit first.
// A two-entry queue sits between the command front end and the execution
// side, so items are taken while a result waits in the output register.
// Reset loads the default registers (disabled, 544..2400 us, 0..180 deg,
// prescale 71, period top 19999), clears the counters and compare values
// and marks the readback stale. When the receiver stalls, the result
// holds, execution waits, the queue fills and item.ready drops.
module servo_pwm_generator #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  spg_cmd_if.sink   item,
  spg_res_if.source result,
  spg_cfg_if.sink   cfg
);

  spg_pkg::cfg_t     regs;
  logic              cfg_wr;
  logic              q_valid;
  spg_pkg::q_entry_t q_data;
  logic              q_pop;
  spg_pkg::map_req_t map_req;
  spg_pkg::map_rsp_t map_rsp;
  logic              out_level;
  logic [15:0]       out_pulse;
  logic [15:0]       out_angle;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.enable       <= 1'b0;
      regs.min_pulse_us <= spg_pkg::RST_MIN_PULSE;
      regs.max_pulse_us <= spg_pkg::RST_MAX_PULSE;
      regs.min_angle    <= spg_pkg::RST_MIN_ANGLE;
      regs.max_angle    <= spg_pkg::RST_MAX_ANGLE;
      regs.prescale     <= spg_pkg::RST_PRESCALE;
      regs.period_top   <= spg_pkg::RST_PERIOD_TOP;
    end else if (cfg_wr) begin
      case (cfg.index)
        spg_pkg::REG_ENABLE:     regs.enable       <= cfg.data[0];
        spg_pkg::REG_MIN_PULSE:  regs.min_pulse_us <= cfg.data;
        spg_pkg::REG_MAX_PULSE:  regs.max_pulse_us <= cfg.data;
        spg_pkg::REG_MIN_ANGLE:  regs.min_angle    <= cfg.data;
        spg_pkg::REG_MAX_ANGLE:  regs.max_angle    <= cfg.data;
        spg_pkg::REG_PRESCALE:   regs.prescale     <= cfg.data;
        spg_pkg::REG_PERIOD_TOP: regs.period_top   <= cfg.data;
        default:                 regs              <= regs;
      endcase
    end
  end

  spg_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  spg_mapper u_mapper (
    .clk (clk),
    .rst (rst),
    .req (map_req),
    .rsp (map_rsp)
  );

  spg_exec #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_exec (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .cfg_wr    (cfg_wr),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .map_req   (map_req),
    .map_rsp   (map_rsp),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_level (out_level),
    .out_pulse (out_pulse),
    .out_angle (out_angle)
  );

  assign result.pwm_level      = out_level;
  assign result.pulse_readback = out_pulse;
  assign result.angle_readback = $signed(out_angle);

endmodule

FILE: hdl/spg_front.sv
`include "servo_pwm_generator_defines.svh"

module spg_front (
  input  logic               clk,
  input  logic               rst,
  spg_cmd_if.sink            item,
  output logic               q_valid,
  output spg_pkg::q_entry_t  q_data,
  input  logic               q_pop
);

  localparam int PTR_W = $clog2(spg_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(spg_pkg::QUEUE_DEPTH + 1);

  spg_pkg::q_entry_t entries [spg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  spg_pkg::q_entry_t incoming;

  assign item.ready = (count != CNT_W'(spg_pkg::QUEUE_DEPTH));
  assign push       = item.valid && item.ready;
  assign q_valid    = (count != '0);
  assign q_data     = entries[rd_ptr];

  // classify the raw command code
  always_comb begin
    incoming.value = item.value;
    case (item.command)
      spg_pkg::CMD_TICK:  incoming.kind = spg_pkg::CMD_TICK;
      spg_pkg::CMD_ANGLE: incoming.kind = spg_pkg::CMD_ANGLE;
      spg_pkg::CMD_PULSE: incoming.kind = spg_pkg::CMD_PULSE;
      default:            incoming.kind = spg_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(spg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(spg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  `SPG_ASSERT_IMP(a_pop_nonempty, clk, rst, q_pop, count != '0)
  `SPG_ASSERT_NXT(a_fill_bound, clk, rst, push && !q_pop,
                  count <= CNT_W'(spg_pkg::QUEUE_DEPTH) && count != '0)

endmodule

FILE: hdl/spg_mapper.sv
module spg_mapper (
  input  logic              clk,
  input  logic              rst,
  input  spg_pkg::map_req_t req,
  output spg_pkg::map_rsp_t rsp
);

  spg_pkg::map_state_t state;
  spg_pkg::map_state_t state_next;

  logic signed [spg_pkg::OP_W-1:0]   diff;
  logic signed [spg_pkg::OP_W-1:0]   rng;
  logic signed [spg_pkg::OP_W-1:0]   span;
  logic signed [spg_pkg::ARG_W-1:0]  out_lo;
  logic signed [spg_pkg::PROD_W-1:0] prod;
  logic signed [spg_pkg::PROD_W-1:0] prod_abs;
  logic signed [spg_pkg::OP_W-1:0]   span_abs;
  logic                              neg;
  logic [spg_pkg::MAG_W-1:0]         quo;
  logic [spg_pkg::DEN_W-1:0]         rem;
  logic [spg_pkg::DEN_W-1:0]         den;
  logic [spg_pkg::DEN_W:0]           trial;
  logic                              ge;
  logic [spg_pkg::CNT_W-1:0]         step;
  logic signed [spg_pkg::RES_W-1:0]  mag_ext;
  logic signed [spg_pkg::RES_W-1:0]  result;
  logic                              can_start;

  assign can_start = (state == spg_pkg::MS_IDLE) || (state == spg_pkg::MS_DONE);

  always_comb begin
    state_next = state;
    case (state)
      spg_pkg::MS_IDLE, spg_pkg::MS_DONE: begin
        state_next = req.start ? spg_pkg::MS_MUL : spg_pkg::MS_IDLE;
      end
      spg_pkg::MS_MUL:  state_next = spg_pkg::MS_PREP;
      spg_pkg::MS_PREP: state_next = (span == '0) ? spg_pkg::MS_DONE : spg_pkg::MS_DIV;
      spg_pkg::MS_DIV: begin
        if (step == spg_pkg::CNT_W'(spg_pkg::MAG_W - 1)) begin
          state_next = spg_pkg::MS_FIX;
        end
      end
      spg_pkg::MS_FIX:  state_next = spg_pkg::MS_DONE;
      default:          state_next = spg_pkg::MS_IDLE;
    endcase
    rsp.busy   = !can_start;
    rsp.done   = (state == spg_pkg::MS_DONE);
    rsp.result = result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spg_pkg::MS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign prod_abs = prod[spg_pkg::PROD_W-1] ? -prod : prod;
  assign span_abs = span[spg_pkg::OP_W-1] ? -span : span;
  assign trial    = {rem, quo[spg_pkg::MAG_W-1]};
  assign ge       = (trial >= {1'b0, den});
  assign mag_ext  = spg_pkg::RES_W'(quo);

  always_ff @(posedge clk) begin
    case (state)
      spg_pkg::MS_IDLE, spg_pkg::MS_DONE: begin
        if (req.start) begin
          diff   <= spg_pkg::OP_W'($signed(req.x)) - spg_pkg::OP_W'($signed(req.in_lo));
          rng    <= spg_pkg::OP_W'($signed(req.out_hi)) - spg_pkg::OP_W'($signed(req.out_lo));
          span   <= spg_pkg::OP_W'($signed(req.in_hi)) - spg_pkg::OP_W'($signed(req.in_lo));
          out_lo <= $signed(req.out_lo);
        end
      end
      spg_pkg::MS_MUL: begin
        prod <= diff * rng;
      end
      spg_pkg::MS_PREP: begin
        neg  <= prod[spg_pkg::PROD_W-1] ^ span[spg_pkg::OP_W-1];
        quo  <= prod_abs[spg_pkg::MAG_W-1:0];
        den  <= span_abs[spg_pkg::DEN_W-1:0];
        rem  <= '0;
        step <= '0;
        if (span == '0) begin
          result <= spg_pkg::RES_W'(out_lo);
        end
      end
      spg_pkg::MS_DIV: begin
        quo  <= {quo[spg_pkg::MAG_W-2:0], ge};
        rem  <= ge ? spg_pkg::DEN_W'(trial - {1'b0, den}) : trial[spg_pkg::DEN_W-1:0];
        step <= step + 1'b1;
      end
      spg_pkg::MS_FIX: begin
        result <= (neg ? -mag_ext : mag_ext) + spg_pkg::RES_W'(out_lo);
      end
      default: begin
        result <= result;
      end
    endcase
  end

endmodule

FILE: hdl/spg_exec.sv
`include "servo_pwm_generator_defines.svh"

module spg_exec #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  spg_pkg::cfg_t      cfg,
  input  logic               cfg_wr,
  input  logic               q_valid,
  input  spg_pkg::q_entry_t  q_data,
  output logic               q_pop,
  output spg_pkg::map_req_t  map_req,
  input  spg_pkg::map_rsp_t  map_rsp,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_level,
  output logic [15:0]        out_pulse,
  output logic [15:0]        out_angle
);

  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  spg_pkg::exec_state_t state;
  spg_pkg::exec_state_t state_next;

  logic [COUNT_WIDTH-1:0] prescale_count;
  logic [COUNT_WIDTH-1:0] prescale_count_next;
  logic [COUNT_WIDTH-1:0] period_count;
  logic [COUNT_WIDTH-1:0] period_count_next;
  logic [15:0]            compare_active;
  logic [15:0]            compare_active_next;
  logic [15:0]            compare_preload;
  logic [15:0]            compare_preload_next;
  logic [15:0]            rb;
  logic [15:0]            rb_next;
  logic                   rb_stale;
  logic                   rb_stale_next;
  logic                   out_load;
  logic                   level_next;
  logic [15:0]            pulse_next;
  logic                   slot_free;
  logic                   ps_hit;
  logic                   pc_hit;
  logic signed [15:0]     deg;

  function automatic logic [15:0] clamp_u16(logic [15:0] v, logic [15:0] lo,
                                            logic [15:0] hi);
    logic [15:0] r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_s16(logic signed [15:0] v,
                                                   logic signed [15:0] lo,
                                                   logic signed [15:0] hi);
    logic signed [15:0] r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [15:0] clamp_map(logic signed [spg_pkg::RES_W-1:0] v,
                                            logic [15:0] lo, logic [15:0] hi);
    logic [15:0] r;
    if (v < $signed(spg_pkg::RES_W'(lo))) r = lo;
    else if (v > $signed(spg_pkg::RES_W'(hi))) r = hi;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic [15:0] fix_angle(logic signed [spg_pkg::RES_W-1:0] v,
                                            logic signed [15:0] alo,
                                            logic signed [15:0] ahi);
    logic signed [15:0] a;
    if (v < spg_pkg::ANG_MIN) a = spg_pkg::ANG_MIN[15:0];
    else if (v > spg_pkg::ANG_MAX) a = spg_pkg::ANG_MAX[15:0];
    else a = v[15:0];
    if (a != alo && a != ahi && a != spg_pkg::ANG_MAX[15:0]) begin
      a = a + 16'sd1;
    end
    return a;
  endfunction

  assign slot_free = !out_valid || out_ready;
  assign ps_hit = (CMP_W'(prescale_count) >= CMP_W'(cfg.prescale)) || (&prescale_count);
  assign pc_hit = (CMP_W'(period_count) >= CMP_W'(cfg.period_top)) || (&period_count);
  assign deg = clamp_s16($signed(q_data.value), $signed(cfg.min_angle),
                         $signed(cfg.max_angle));

  always_comb begin
    state_next           = state;
    prescale_count_next  = prescale_count;
    period_count_next    = period_count;
    compare_active_next  = compare_active;
    compare_preload_next = compare_preload;
    rb_next              = rb;
    rb_stale_next        = rb_stale;
    q_pop                = 1'b0;
    out_load             = 1'b0;
    map_req              = '0;

    case (state)
      spg_pkg::EX_RUN: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          if (!cfg.enable) begin
            prescale_count_next  = '0;
            period_count_next    = '0;
            compare_active_next  = '0;
            compare_preload_next = '0;
          end else begin
            case (q_data.kind)
              spg_pkg::CMD_TICK: begin
                if (ps_hit) begin
                  prescale_count_next = '0;
                  if (pc_hit) begin
                    period_count_next   = '0;
                    compare_active_next = compare_preload;
                  end else begin
                    period_count_next = period_count + 1'b1;
                  end
                end else begin
                  prescale_count_next = prescale_count + 1'b1;
                end
              end
              spg_pkg::CMD_PULSE: begin
                compare_preload_next = clamp_u16(q_data.value, cfg.min_pulse_us,
                                                 cfg.max_pulse_us);
                rb_stale_next = 1'b1;
              end
              default: begin
                compare_preload_next = compare_preload;
              end
            endcase
          end
          if (cfg.enable && q_data.kind == spg_pkg::CMD_ANGLE) begin
            map_req.start  = 1'b1;
            map_req.x      = spg_pkg::ARG_W'(deg);
            map_req.in_lo  = spg_pkg::ARG_W'($signed(cfg.min_angle));
            map_req.in_hi  = spg_pkg::ARG_W'($signed(cfg.max_angle));
            map_req.out_lo = spg_pkg::ARG_W'(cfg.min_pulse_us);
            map_req.out_hi = spg_pkg::ARG_W'(cfg.max_pulse_us);
            state_next     = spg_pkg::EX_ANGLE;
          end else if (rb_stale_next) begin
            map_req.start = 1'b1;
            state_next    = spg_pkg::EX_READ;
          end else begin
            out_load = 1'b1;
          end
        end
      end
      spg_pkg::EX_ANGLE: begin
        if (map_rsp.done) begin
          compare_preload_next = clamp_map($signed(map_rsp.result), cfg.min_pulse_us,
                                           cfg.max_pulse_us);
          rb_stale_next = 1'b1;
          map_req.start = 1'b1;
          state_next    = spg_pkg::EX_READ;
        end
      end
      spg_pkg::EX_READ: begin
        if (map_rsp.done) begin
          rb_next       = fix_angle($signed(map_rsp.result), $signed(cfg.min_angle),
                                    $signed(cfg.max_angle));
          rb_stale_next = 1'b0;
          out_load      = 1'b1;
          state_next    = spg_pkg::EX_RUN;
        end
      end
      default: begin
        state_next = spg_pkg::EX_RUN;
      end
    endcase

    pulse_next = cfg.enable ? compare_preload_next : 16'd0;
    level_next = cfg.enable && (CMP_W'(period_count_next) < CMP_W'(compare_active_next));

    // readback request: pulse range onto angle range
    if (map_req.start && state_next == spg_pkg::EX_READ) begin
      map_req.x      = spg_pkg::ARG_W'(pulse_next);
      map_req.in_lo  = spg_pkg::ARG_W'(cfg.min_pulse_us);
      map_req.in_hi  = spg_pkg::ARG_W'(cfg.max_pulse_us);
      map_req.out_lo = spg_pkg::ARG_W'($signed(cfg.min_angle));
      map_req.out_hi = spg_pkg::ARG_W'($signed(cfg.max_angle));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= spg_pkg::EX_RUN;
      prescale_count  <= '0;
      period_count    <= '0;
      compare_active  <= '0;
      compare_preload <= '0;
      rb_stale        <= 1'b1;
      out_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      prescale_count  <= prescale_count_next;
      period_count    <= period_count_next;
      compare_active  <= compare_active_next;
      compare_preload <= compare_preload_next;
      rb_stale        <= rb_stale_next | cfg_wr;
      out_valid       <= out_load | (out_valid & ~out_ready);
    end
  end

  always_ff @(posedge clk) begin
    rb <= rb_next;
    if (out_load) begin
      out_level <= level_next;
      out_pulse <= pulse_next;
      out_angle <= rb_next;
    end
  end

  `SPG_ASSERT_IMP(a_map_start_free, clk, rst, map_req.start, !map_rsp.busy)
  `SPG_ASSERT_NXT(a_disabled_clears, clk, rst, q_pop && !cfg.enable,
                  period_count == '0 && compare_active == '0 && prescale_count == '0)

endmodule

FILE: tb/servo_readback_check.sv
`timescale 1ns / 1ps

module servo_readback_check #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  spg_cmd_if   item,
  spg_res_if   result,
  spg_cfg_if   cfg,
  output int   pending,
  output int   failures
);

  typedef struct packed {
    logic               level;
    logic [15:0]        pulse;
    logic signed [15:0] angle;
  } servo_readback_t;

  spg_pkg::cfg_t          settings;
  logic [COUNT_WIDTH-1:0] prescale_count;
  logic [COUNT_WIDTH-1:0] period_count;
  logic [15:0]            compare_active;
  logic [15:0]            compare_preload;
  servo_readback_t        expected_readbacks[$];
  int                     fail_count = 0;

  function automatic longint bound(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic longint scale_span(longint x, longint in_lo, longint in_hi,
                                        longint out_lo, longint out_hi);
    if (in_hi == in_lo) return out_lo;
    return (x - in_lo) * (out_hi - out_lo) / (in_hi - in_lo) + out_lo;
  endfunction

  function automatic servo_readback_t predict_readback(spg_pkg::cmd_t kind,
                                                       logic [15:0] raw);
    servo_readback_t r;
    longint alo, ahi, plo, phi, deg, a;
    alo = longint'($signed(settings.min_angle));
    ahi = longint'($signed(settings.max_angle));
    plo = longint'(settings.min_pulse_us);
    phi = longint'(settings.max_pulse_us);
    if (!settings.enable) begin
      prescale_count  = '0;
      period_count    = '0;
      compare_active  = '0;
      compare_preload = '0;
    end else begin
      case (kind)
        spg_pkg::CMD_TICK: begin
          if (prescale_count >= settings.prescale || prescale_count == '1) begin
            prescale_count = '0;
            if (period_count >= settings.period_top || period_count == '1) begin
              period_count   = '0;
              compare_active = compare_preload;
            end else begin
              period_count = period_count + 1'b1;
            end
          end else begin
            prescale_count = prescale_count + 1'b1;
          end
        end
        spg_pkg::CMD_ANGLE: begin
          deg = bound(longint'($signed(raw)), alo, ahi);
          compare_preload = 16'(bound(scale_span(deg, alo, ahi, plo, phi), plo, phi));
        end
        spg_pkg::CMD_PULSE: begin
          compare_preload = 16'(bound(longint'(raw), plo, phi));
        end
        default: ;
      endcase
    end
    r.level = settings.enable && (period_count < compare_active);
    r.pulse = settings.enable ? compare_preload : 16'h0000;
    a = bound(scale_span(longint'(r.pulse), plo, phi, alo, ahi), -32768, 32767);
    if (a != alo && a != ahi) begin
      a = bound(a + 1, -32768, 32767);
    end
    r.angle = 16'(a);
    return r;
  endfunction

  always @(posedge clk) begin : track
    servo_readback_t want;
    if (rst) begin
      settings = '{enable: 1'b0,
                   min_pulse_us: spg_pkg::RST_MIN_PULSE,
                   max_pulse_us: spg_pkg::RST_MAX_PULSE,
                   min_angle: spg_pkg::RST_MIN_ANGLE,
                   max_angle: spg_pkg::RST_MAX_ANGLE,
                   prescale: spg_pkg::RST_PRESCALE,
                   period_top: spg_pkg::RST_PERIOD_TOP};
      prescale_count  = '0;
      period_count    = '0;
      compare_active  = '0;
      compare_preload = '0;
      expected_readbacks.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_readbacks.size() == 0) begin
          $error("result transfer with no item waiting: pwm_level %0d pulse %0d angle %0d",
                 result.pwm_level, result.pulse_readback, result.angle_readback);
          fail_count++;
        end else begin
          want = expected_readbacks.pop_front();
          if (result.pwm_level !== want.level) begin
            $error("pwm_level: expected %0d, got %0d", want.level, result.pwm_level);
            fail_count++;
          end
          if (result.pulse_readback !== want.pulse) begin
            $error("pulse_readback: expected %0d, got %0d", want.pulse, result.pulse_readback);
            fail_count++;
          end
          if (result.angle_readback !== want.angle) begin
            $error("angle_readback: expected %0d, got %0d", want.angle, result.angle_readback);
            fail_count++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          spg_pkg::REG_ENABLE:     settings.enable       = cfg.data[0];
          spg_pkg::REG_MIN_PULSE:  settings.min_pulse_us = cfg.data;
          spg_pkg::REG_MAX_PULSE:  settings.max_pulse_us = cfg.data;
          spg_pkg::REG_MIN_ANGLE:  settings.min_angle    = cfg.data;
          spg_pkg::REG_MAX_ANGLE:  settings.max_angle    = cfg.data;
          spg_pkg::REG_PRESCALE:   settings.prescale     = cfg.data;
          spg_pkg::REG_PERIOD_TOP: settings.period_top   = cfg.data;
          default: ;
        endcase
      end
      if (item.valid && item.ready) begin
        expected_readbacks.push_back(predict_readback(spg_pkg::cmd_t'(item.command),
                                                      item.value));
      end
    end
    pending  <= expected_readbacks.size();
    failures <= fail_count;
  end

endmodule

FILE: tb/servo_pwm_generator_test.sv
`timescale 1ns / 1ps

module servo_pwm_generator_test;

  localparam int SQUEEZE_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst;
  bit          calm;
  bit          squeeze_req;
  bit          squeeze_done;
  int          pending;
  int          failures;
  logic [15:0] shadow [0:6];

  spg_cmd_if item_ch();
  spg_res_if result_ch();
  spg_cfg_if cfg_ch();

  servo_pwm_generator uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  servo_readback_check readback_check (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (result_ch),
    .cfg      (cfg_ch),
    .pending  (pending),
    .failures (failures)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [15:0] pick_between(int a, int b);
    int lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return 16'(lo - 3 + int'($urandom_range(0, hi - lo + 6)));
  endfunction

  task automatic send_item(spg_pkg::cmd_t kind, logic [15:0] value);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.command <= kind;
    item_ch.value   <= value;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic idle_items();
    @(negedge clk);
    item_ch.valid <= 1'b0;
  endtask

  task automatic write_reg(logic [2:0] index, logic [15:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    shadow[index] = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(int count);
    spg_pkg::cmd_t kind;
    logic [15:0]   value;
    int            roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 9);
      if (roll <= 5) kind = spg_pkg::CMD_TICK;
      else if (roll == 6) kind = spg_pkg::CMD_ANGLE;
      else if (roll == 7) kind = spg_pkg::CMD_PULSE;
      else if (roll == 8) kind = spg_pkg::CMD_NONE;
      else kind = spg_pkg::cmd_t'($urandom_range(0, 3));
      value = 16'($urandom);
      if ($urandom_range(0, 1) == 1) begin
        if (kind == spg_pkg::CMD_ANGLE)
          value = pick_between($signed(shadow[spg_pkg::REG_MIN_ANGLE]),
                               $signed(shadow[spg_pkg::REG_MAX_ANGLE]));
        else if (kind == spg_pkg::CMD_PULSE)
          value = pick_between(shadow[spg_pkg::REG_MIN_PULSE],
                               shadow[spg_pkg::REG_MAX_PULSE]);
      end
      send_item(kind, value);
    end
    idle_items();
    settle();
  endtask

  task automatic random_settings(int mode);
    case (mode)
      0: begin
        write_reg(spg_pkg::REG_MIN_PULSE, 16'($urandom_range(0, 30)));
        write_reg(spg_pkg::REG_MAX_PULSE, 16'($urandom_range(10, 80)));
        write_reg(spg_pkg::REG_MIN_ANGLE, 16'(int'($urandom_range(0, 180)) - 90));
        write_reg(spg_pkg::REG_MAX_ANGLE, 16'(int'($urandom_range(0, 180)) - 90));
        write_reg(spg_pkg::REG_PRESCALE, 16'($urandom_range(0, 2)));
        write_reg(spg_pkg::REG_PERIOD_TOP, 16'($urandom_range(1, 60)));
      end
      1: begin
        write_reg(spg_pkg::REG_MIN_PULSE, 16'($urandom));
        write_reg(spg_pkg::REG_MAX_PULSE, 16'($urandom));
        write_reg(spg_pkg::REG_MIN_ANGLE, 16'($urandom));
        write_reg(spg_pkg::REG_MAX_ANGLE, 16'($urandom));
        write_reg(spg_pkg::REG_PRESCALE, 16'($urandom_range(0, 3)));
        write_reg(spg_pkg::REG_PERIOD_TOP, 16'($urandom_range(1, 200)));
      end
      default: begin
        write_reg(spg_pkg::REG_MIN_PULSE, 16'($urandom_range(0, 3000)));
        write_reg(spg_pkg::REG_MAX_PULSE, 16'($urandom_range(0, 3000)));
        write_reg(spg_pkg::REG_MIN_ANGLE, 16'(int'($urandom_range(0, 360)) - 180));
        write_reg(spg_pkg::REG_MAX_ANGLE, 16'(int'($urandom_range(0, 360)) - 180));
        write_reg(spg_pkg::REG_PRESCALE, 16'($urandom_range(0, 1)));
        write_reg(spg_pkg::REG_PERIOD_TOP, 16'($urandom_range(100, 3000)));
      end
    endcase
  endtask

  initial begin : drain
    int stall;
    stall = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeeze_done) begin
        result_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
        squeeze_done = 1'b1;
      end else if (stall > 0) begin
        result_ch.ready <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        result_ch.ready <= 1'b0;
        stall = $urandom_range(0, 4);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    rst             = 1'b1;
    calm            = 1'b0;
    squeeze_req     = 1'b0;
    item_ch.valid   = 1'b0;
    item_ch.command = spg_pkg::CMD_TICK;
    item_ch.value   = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = spg_pkg::REG_ENABLE;
    cfg_ch.data     = '0;
    shadow[spg_pkg::REG_ENABLE]     = '0;
    shadow[spg_pkg::REG_MIN_PULSE]  = spg_pkg::RST_MIN_PULSE;
    shadow[spg_pkg::REG_MAX_PULSE]  = spg_pkg::RST_MAX_PULSE;
    shadow[spg_pkg::REG_MIN_ANGLE]  = spg_pkg::RST_MIN_ANGLE;
    shadow[spg_pkg::REG_MAX_ANGLE]  = spg_pkg::RST_MAX_ANGLE;
    shadow[spg_pkg::REG_PRESCALE]   = spg_pkg::RST_PRESCALE;
    shadow[spg_pkg::REG_PERIOD_TOP] = spg_pkg::RST_PERIOD_TOP;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // disabled after reset: everything ignored
    send_item(spg_pkg::CMD_TICK, 16'd0);
    send_item(spg_pkg::CMD_ANGLE, 16'd90);
    send_item(spg_pkg::CMD_PULSE, 16'd1500);
    send_item(spg_pkg::CMD_NONE, 16'hffff);
    idle_items();
    settle();

    // default ranges; compare sits above the short period
    write_reg(spg_pkg::REG_ENABLE, 16'd1);
    write_reg(spg_pkg::REG_PRESCALE, 16'd0);
    write_reg(spg_pkg::REG_PERIOD_TOP, 16'd3);
    send_item(spg_pkg::CMD_ANGLE, 16'h8000);
    send_item(spg_pkg::CMD_ANGLE, 16'h7fff);
    send_item(spg_pkg::CMD_ANGLE, 16'd0);
    send_item(spg_pkg::CMD_ANGLE, 16'd180);
    send_item(spg_pkg::CMD_ANGLE, 16'd90);
    send_item(spg_pkg::CMD_PULSE, 16'd0);
    send_item(spg_pkg::CMD_PULSE, 16'hffff);
    send_item(spg_pkg::CMD_PULSE, 16'd1000);
    send_item(spg_pkg::CMD_NONE, 16'h5a5a);
    repeat (5) send_item(spg_pkg::CMD_TICK, 16'hffff);
    idle_items();
    settle();

    // empty angle range
    write_reg(spg_pkg::REG_MIN_ANGLE, 16'd45);
    write_reg(spg_pkg::REG_MAX_ANGLE, 16'd45);
    send_item(spg_pkg::CMD_ANGLE, 16'd30);
    send_item(spg_pkg::CMD_PULSE, 16'd1000);
    send_item(spg_pkg::CMD_TICK, 16'd0);
    idle_items();
    settle();

    // empty pulse range
    write_reg(spg_pkg::REG_MIN_ANGLE, 16'd0);
    write_reg(spg_pkg::REG_MAX_ANGLE, 16'd180);
    write_reg(spg_pkg::REG_MIN_PULSE, 16'd1500);
    write_reg(spg_pkg::REG_MAX_PULSE, 16'd1500);
    send_item(spg_pkg::CMD_ANGLE, 16'd90);
    send_item(spg_pkg::CMD_PULSE, 16'd7);
    idle_items();
    settle();

    // inverted ranges
    write_reg(spg_pkg::REG_MIN_ANGLE, 16'd180);
    write_reg(spg_pkg::REG_MAX_ANGLE, 16'd0);
    write_reg(spg_pkg::REG_MIN_PULSE, 16'd2400);
    write_reg(spg_pkg::REG_MAX_PULSE, 16'd544);
    send_item(spg_pkg::CMD_ANGLE, 16'd90);
    send_item(spg_pkg::CMD_PULSE, 16'd1000);
    idle_items();
    settle();

    // widest ranges and slowest timebase
    write_reg(spg_pkg::REG_MIN_ANGLE, 16'h8000);
    write_reg(spg_pkg::REG_MAX_ANGLE, 16'h7fff);
    write_reg(spg_pkg::REG_MIN_PULSE, 16'd0);
    write_reg(spg_pkg::REG_MAX_PULSE, 16'hffff);
    write_reg(spg_pkg::REG_PRESCALE, 16'hffff);
    write_reg(spg_pkg::REG_PERIOD_TOP, 16'hffff);
    run_phase(20);

    // fastest prescale, short period
    write_reg(spg_pkg::REG_MAX_PULSE, 16'd3);
    write_reg(spg_pkg::REG_PRESCALE, 16'd0);
    write_reg(spg_pkg::REG_PERIOD_TOP, 16'd1);
    run_phase(20);

    for (int p = 0; p < 11; p++) begin
      if (p == 10) calm = 1'b1;
      random_settings(p % 3);
      write_reg(spg_pkg::REG_ENABLE, (p == 4) ? 16'd0 : 16'd1);
      if (p == 6) squeeze_req = 1'b1;
      run_phase(50);
    end

    repeat (100) @(posedge clk);
    @(negedge clk);
    if (failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
